[rtl/rfc_pkg.sv]
// Shared constants, cell operation codes and controller states of the rainflow counter.
package rfc_pkg;

  // Default sizes
  localparam int STACK_DEPTH_DEF = 32;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int TIME_BITS_DEF   = 32;

  // Fixed field widths
  localparam int REPEAT_BITS = 16;
  localparam int WEIGHT_BITS = REPEAT_BITS + 1;
  localparam int STATUS_BITS = 2;

  localparam logic [REPEAT_BITS-1:0] REPEAT_RESET = REPEAT_BITS'(1);

  // Result status codes
  localparam logic [STATUS_BITS-1:0] STATUS_RANGE       = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_NO_REVERSAL = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW    = 2'd2;

  // What every stack cell does in a cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT,     // take the entry of the cell above (cell 0 takes the new point)
    CELL_COLLAPSE   // take the entry two cells below (cell 0 keeps its entry)
  } cell_op_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_PUSH,
    ST_CHECK,
    ST_ALIGN,
    ST_FLUSH,
    ST_ERROR
  } rfc_state_t;

endpackage

[rtl/rainflow_cycle_counter_top.sv]
// Rainflow cycle counter top level: turning point detection, three-point rules, flush.
//
// Usage: stress samples enter on the input channel (in_valid / in_stall) with
// a timestamp; last_sample marks the final sample of a history. Each counted
// range, the no-reversal error or a stack overflow leaves on the output
// channel (out_valid / out_stall) as one request; last_result marks the last
// request caused by a sample. repeat_count is written through cfg_write_en /
// cfg_write_data and scales the half-cycle weights; the user must write it only
// while the block is idle, which the block itself does not enforce. Samples are
// taken one at a time. A sample that settles no turning point is accepted and
// then decided. A turning point adds a push and a check, plus one more check
// per counted range; a push onto a full stack reports an overflow and is not
// checked. The final sample also shifts the cell chain until the oldest entry
// sits in the last cell, then gives one range per cycle while not stalled.
// Reset: history cleared, stack empty, repeat_count 1, output register empty.
// When out_stall holds a result in the output register, the controller waits
// in place and in_stall stays high until the sample is fully processed.
module rainflow_cycle_counter_top #(
  parameter int STACK_DEPTH = rfc_pkg::STACK_DEPTH_DEF,
  parameter int SAMPLE_BITS = rfc_pkg::SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = rfc_pkg::TIME_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration
  input  logic                              cfg_write_en,
  input  logic [rfc_pkg::REPEAT_BITS-1:0]   cfg_write_data,
  // Sample channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [SAMPLE_BITS-1:0]     sample_value,
  input  logic        [TIME_BITS-1:0]       sample_time,
  input  logic                              last_sample,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rfc_pkg::STATUS_BITS-1:0]   status,
  output logic [rfc_pkg::WEIGHT_BITS-1:0]   half_cycles,
  output logic [SAMPLE_BITS-1:0]            stress_range,
  output logic signed [SAMPLE_BITS:0]       level_sum,
  output logic [TIME_BITS-1:0]              start_time,
  output logic [TIME_BITS-1:0]              end_time,
  output logic                              last_result
);
  import rfc_pkg::*;

  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int IDX3  = (STACK_DEPTH > 3) ? 3 : STACK_DEPTH - 1;
  localparam int IDX4  = (STACK_DEPTH > 4) ? 4 : STACK_DEPTH - 1;

  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_TWO  = 2'd2;

  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_TWO   = CNT_W'(2);
  localparam logic [CNT_W-1:0] CNT_THREE = CNT_W'(3);
  localparam logic [CNT_W-1:0] CNT_FIVE  = CNT_W'(5);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(STACK_DEPTH);

  // |a - b| of two samples; fits the unsigned sample width
  function automatic logic [SAMPLE_BITS-1:0] abs_diff(
    input logic signed [SAMPLE_BITS-1:0] a,
    input logic signed [SAMPLE_BITS-1:0] b
  );
    logic signed [SAMPLE_BITS:0] d;
    d = {a[SAMPLE_BITS-1], a} - {b[SAMPLE_BITS-1], b};
    if (d[SAMPLE_BITS]) d = -d;
    return d[SAMPLE_BITS-1:0];
  endfunction

  // a + b, twice the mean
  function automatic logic signed [SAMPLE_BITS:0] pair_sum(
    input logic signed [SAMPLE_BITS-1:0] a,
    input logic signed [SAMPLE_BITS-1:0] b
  );
    return {a[SAMPLE_BITS-1], a} + {b[SAMPLE_BITS-1], b};
  endfunction

  rfc_state_t state, state_next;

  // Registers
  logic [REPEAT_BITS-1:0]        repeat_count;
  logic signed [SAMPLE_BITS-1:0] item_value;
  logic [TIME_BITS-1:0]          item_time;
  logic                          item_last;
  logic signed [SAMPLE_BITS-1:0] held_value, held_value_next;
  logic [TIME_BITS-1:0]          held_time, held_time_next;
  logic [1:0]                    samples_seen, samples_seen_next;
  logic signed [SAMPLE_BITS-1:0] last_turn, last_turn_next;
  logic                          inner_found, inner_found_next;
  logic signed [SAMPLE_BITS-1:0] pend_value, pend_value_next;
  logic [TIME_BITS-1:0]          pend_time, pend_time_next;
  logic                          final_pushed, final_pushed_next;
  logic [CNT_W-1:0]              stack_count, stack_count_next;
  logic [CNT_W-1:0]              flush_left, flush_left_next;

  // Output register load values
  logic                          out_load;
  logic [STATUS_BITS-1:0]        status_next;
  logic [WEIGHT_BITS-1:0]        half_cycles_next;
  logic [SAMPLE_BITS-1:0]        stress_range_next;
  logic signed [SAMPLE_BITS:0]   level_sum_next;
  logic [TIME_BITS-1:0]          start_time_next;
  logic [TIME_BITS-1:0]          end_time_next;
  logic                          last_result_next;

  // Stack chain
  cell_op_t                      stack_op;
  logic signed [SAMPLE_BITS-1:0] cell_value [STACK_DEPTH];
  logic [TIME_BITS-1:0]          cell_time  [STACK_DEPTH];

  logic                          in_accept;
  logic                          out_free;
  logic                          turn;
  logic [SAMPLE_BITS-1:0]        x_top, y_top, x_after, y_after;
  logic                          fire, more;
  logic [WEIGHT_BITS-1:0]        weight_half, weight_full;
  logic                          loop_done, clear_hist;

  assign in_stall  = (state != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // Held sample is a turning point against the last one and the new sample
  assign turn = (samples_seen == SEEN_TWO) &&
                (((held_value < last_turn) && (held_value < item_value)) ||
                 ((held_value > last_turn) && (held_value > item_value)));

  // Three-point rule on the top entries, and on the entries left after a full cycle
  assign x_top   = abs_diff(cell_value[1], cell_value[0]);
  assign y_top   = abs_diff(cell_value[2], cell_value[1]);
  assign x_after = abs_diff(cell_value[IDX3], cell_value[0]);
  assign y_after = abs_diff(cell_value[IDX4], cell_value[IDX3]);
  assign fire    = (stack_count >= CNT_THREE) && !(x_top < y_top);
  assign more    = (stack_count >= CNT_FIVE) && !(x_after < y_after);

  assign weight_half = {1'b0, repeat_count};
  assign weight_full = {repeat_count, 1'b0};

  rfc_chain #(
    .DEPTH       (STACK_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS),
    .TIME_BITS   (TIME_BITS)
  ) u_chain (
    .clk        (clk),
    .op         (stack_op),
    .push_value (pend_value),
    .push_time  (pend_time),
    .cell_value (cell_value),
    .cell_time  (cell_time)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, stack operation and result generation
  always_comb begin
    state_next         = state;
    stack_op           = CELL_HOLD;
    held_value_next    = held_value;
    held_time_next     = held_time;
    samples_seen_next  = samples_seen;
    last_turn_next     = last_turn;
    inner_found_next   = inner_found;
    pend_value_next    = pend_value;
    pend_time_next     = pend_time;
    final_pushed_next  = final_pushed;
    stack_count_next   = stack_count;
    flush_left_next    = flush_left;
    out_load           = 1'b0;
    status_next        = STATUS_RANGE;
    half_cycles_next   = '0;
    stress_range_next  = '0;
    level_sum_next     = '0;
    start_time_next    = '0;
    end_time_next      = '0;
    last_result_next   = 1'b0;
    loop_done          = 1'b0;
    clear_hist         = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_accept) state_next = ST_DECIDE;
      end

      ST_DECIDE: begin
        final_pushed_next = 1'b0;
        if (samples_seen == SEEN_NONE) begin
          if (item_last) begin
            state_next = ST_ERROR;
          end else begin
            // First sample of a history is always a turning point
            held_value_next   = item_value;
            held_time_next    = item_time;
            last_turn_next    = item_value;
            samples_seen_next = SEEN_ONE;
            pend_value_next   = item_value;
            pend_time_next    = item_time;
            state_next        = ST_PUSH;
          end
        end else begin
          if (turn) begin
            last_turn_next   = held_value;
            inner_found_next = 1'b1;
            pend_value_next  = held_value;
            pend_time_next   = held_time;
            state_next       = ST_PUSH;
          end
          if (!item_last) begin
            held_value_next   = item_value;
            held_time_next    = item_time;
            samples_seen_next = SEEN_TWO;
            if (!turn) state_next = ST_IDLE;
          end else if (!(inner_found || turn)) begin
            state_next = ST_ERROR;
          end else if (!turn) begin
            // Last sample is a turning point of its own
            pend_value_next   = item_value;
            pend_time_next    = item_time;
            final_pushed_next = 1'b1;
            state_next        = ST_PUSH;
          end
        end
      end

      ST_PUSH: begin
        if (stack_count == CNT_FULL) begin
          // Full stack: report and drop the point
          if (out_free) begin
            out_load         = 1'b1;
            status_next      = STATUS_OVERFLOW;
            start_time_next  = pend_time;
            end_time_next    = pend_time;
            last_result_next = !item_last;
            loop_done        = 1'b1;
          end
        end else begin
          stack_op         = CELL_SHIFT;
          stack_count_next = stack_count + CNT_ONE;
          state_next       = ST_CHECK;
        end
      end

      ST_CHECK: begin
        if (!fire) begin
          loop_done = 1'b1;
        end else if (out_free) begin
          // Range between entries two and one below the top
          out_load          = 1'b1;
          status_next       = STATUS_RANGE;
          stress_range_next = y_top;
          level_sum_next    = pair_sum(cell_value[2], cell_value[1]);
          start_time_next   = cell_time[2];
          end_time_next     = cell_time[1];
          if (stack_count == CNT_THREE) begin
            // Involves the start point: half cycle, drop the bottom entry
            half_cycles_next = weight_half;
            last_result_next = !item_last;
            stack_count_next = CNT_TWO;
          end else begin
            half_cycles_next = weight_full;
            last_result_next = !item_last && !more;
            stack_op         = CELL_COLLAPSE;
            stack_count_next = stack_count - CNT_TWO;
          end
        end
      end

      ST_ALIGN: begin
        // Move the oldest entry down to the last cell
        if (stack_count != CNT_FULL) begin
          stack_op         = CELL_SHIFT;
          stack_count_next = stack_count + CNT_ONE;
        end else begin
          state_next = ST_FLUSH;
        end
      end

      ST_FLUSH: begin
        // Residue as half cycles, oldest pair first
        if (out_free) begin
          out_load          = 1'b1;
          status_next       = STATUS_RANGE;
          half_cycles_next  = weight_half;
          stress_range_next = abs_diff(cell_value[STACK_DEPTH-1], cell_value[STACK_DEPTH-2]);
          level_sum_next    = pair_sum(cell_value[STACK_DEPTH-1], cell_value[STACK_DEPTH-2]);
          start_time_next   = cell_time[STACK_DEPTH-1];
          end_time_next     = cell_time[STACK_DEPTH-2];
          last_result_next  = (flush_left == CNT_ONE);
          stack_op          = CELL_SHIFT;
          flush_left_next   = flush_left - CNT_ONE;
          if (flush_left == CNT_ONE) begin
            clear_hist = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end

      ST_ERROR: begin
        if (out_free) begin
          out_load         = 1'b1;
          status_next      = STATUS_NO_REVERSAL;
          last_result_next = 1'b1;
          clear_hist       = 1'b1;
          state_next       = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // End of the rule loop after a push
    if (loop_done) begin
      if (!item_last) begin
        state_next = ST_IDLE;
      end else if (!final_pushed) begin
        pend_value_next   = item_value;
        pend_time_next    = item_time;
        final_pushed_next = 1'b1;
        state_next        = ST_PUSH;
      end else begin
        flush_left_next = stack_count - CNT_ONE;
        state_next      = ST_ALIGN;
      end
    end

    // Ready for a new history
    if (clear_hist) begin
      held_value_next   = '0;
      held_time_next    = '0;
      samples_seen_next = SEEN_NONE;
      last_turn_next    = '0;
      inner_found_next  = 1'b0;
      stack_count_next  = '0;
    end
  end

  // History and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_count <= REPEAT_RESET;
      held_value   <= '0;
      held_time    <= '0;
      samples_seen <= SEEN_NONE;
      last_turn    <= '0;
      inner_found  <= 1'b0;
      final_pushed <= 1'b0;
      stack_count  <= '0;
      flush_left   <= '0;
    end else begin
      if (cfg_write_en) repeat_count <= cfg_write_data;
      held_value   <= held_value_next;
      held_time    <= held_time_next;
      samples_seen <= samples_seen_next;
      last_turn    <= last_turn_next;
      inner_found  <= inner_found_next;
      final_pushed <= final_pushed_next;
      stack_count  <= stack_count_next;
      flush_left   <= flush_left_next;
    end
  end

  // Captured sample and pending push point
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_value <= sample_value;
      item_time  <= sample_time;
      item_last  <= last_sample;
    end
    pend_value <= pend_value_next;
    pend_time  <= pend_time_next;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status       <= status_next;
      half_cycles  <= half_cycles_next;
      stress_range <= stress_range_next;
      level_sum    <= level_sum_next;
      start_time   <= start_time_next;
      end_time     <= end_time_next;
      last_result  <= last_result_next;
    end
  end

endmodule

[rtl/rfc_cell.sv]
// One reversal stack cell: holds a turning point and moves it along the chain.
module rfc_cell #(
  parameter int SAMPLE_BITS = rfc_pkg::SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = rfc_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  rfc_pkg::cell_op_t             op,
  input  logic signed [SAMPLE_BITS-1:0] up_value,
  input  logic        [TIME_BITS-1:0]   up_time,
  input  logic signed [SAMPLE_BITS-1:0] skip_value,
  input  logic        [TIME_BITS-1:0]   skip_time,
  output logic signed [SAMPLE_BITS-1:0] value,
  output logic        [TIME_BITS-1:0]   time_stamp
);
  import rfc_pkg::*;

  // Entry register, no reset: only entries below the fill count are read
  always_ff @(posedge clk) begin
    unique case (op)
      CELL_SHIFT: begin
        value      <= up_value;
        time_stamp <= up_time;
      end
      CELL_COLLAPSE: begin
        value      <= skip_value;
        time_stamp <= skip_time;
      end
      CELL_HOLD: begin
        value      <= value;
        time_stamp <= time_stamp;
      end
      default: begin
        value      <= value;
        time_stamp <= time_stamp;
      end
    endcase
  end

endmodule

[rtl/rfc_chain.sv]
// Reversal stack as a chain of cells; cell 0 is the top of the stack.
module rfc_chain #(
  parameter int DEPTH       = rfc_pkg::STACK_DEPTH_DEF,
  parameter int SAMPLE_BITS = rfc_pkg::SAMPLE_BITS_DEF,
  parameter int TIME_BITS   = rfc_pkg::TIME_BITS_DEF
) (
  input  logic                          clk,
  input  rfc_pkg::cell_op_t             op,
  input  logic signed [SAMPLE_BITS-1:0] push_value,
  input  logic        [TIME_BITS-1:0]   push_time,
  output logic signed [SAMPLE_BITS-1:0] cell_value [DEPTH],
  output logic        [TIME_BITS-1:0]   cell_time  [DEPTH]
);
  import rfc_pkg::*;

  cell_op_t top_op;

  // The top cell keeps its entry when two entries below it are removed
  assign top_op = (op == CELL_COLLAPSE) ? CELL_HOLD : op;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [SAMPLE_BITS-1:0] up_value;
    logic        [TIME_BITS-1:0]   up_time;
    logic signed [SAMPLE_BITS-1:0] skip_value;
    logic        [TIME_BITS-1:0]   skip_time;
    cell_op_t                      cell_op;

    if (i == 0) begin : g_top
      assign up_value = push_value;
      assign up_time  = push_time;
      assign cell_op  = top_op;
    end else begin : g_inner
      assign up_value = cell_value[i-1];
      assign up_time  = cell_time[i-1];
      assign cell_op  = op;
    end

    // Bottom two cells have nothing two below them; they hold
    if (i + 2 < DEPTH) begin : g_skip
      assign skip_value = cell_value[i+2];
      assign skip_time  = cell_time[i+2];
    end else begin : g_end
      assign skip_value = cell_value[i];
      assign skip_time  = cell_time[i];
    end

    rfc_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .TIME_BITS   (TIME_BITS)
    ) u_cell (
      .clk        (clk),
      .op         (cell_op),
      .up_value   (up_value),
      .up_time    (up_time),
      .skip_value (skip_value),
      .skip_time  (skip_time),
      .value      (cell_value[i]),
      .time_stamp (cell_time[i])
    );
  end

endmodule
